### rtl/core/npps_pkg.sv
// ----------------------------------------------------------------------------
// NES pad poll sequencer package
// Shared types and constants for the pad poll sequencer and its lanes.
// ----------------------------------------------------------------------------
package npps_pkg;

  // Number of data pins on the input item, and so the most pads that can be read.
  localparam int NPPS_PIN_SLOTS    = 4;
  // Bits shifted out of every pad per poll.
  localparam int NPPS_BITS_PER_PAD = 8;
  localparam int NPPS_BIT_IDX_W    = $clog2(NPPS_BITS_PER_PAD);
  localparam int NPPS_BUTTONS_W    = 32;

  localparam logic [NPPS_BIT_IDX_W-1:0] NPPS_LAST_BIT =
    NPPS_BIT_IDX_W'(NPPS_BITS_PER_PAD - 1);

  // Poll stages. Code 7 is never entered.
  typedef enum logic [2:0] {
    ST_LATCH_ON   = 3'd0,
    ST_SAMPLE_A   = 3'd1,
    ST_WAIT_A     = 3'd2,
    ST_LATCH_OFF  = 3'd3,
    ST_WAIT_B     = 3'd4,
    ST_CLOCK_UP   = 3'd5,
    ST_CLOCK_DOWN = 3'd6
  } npps_stage_t;

  // Control from the sequencer to the sampling lanes.
  typedef struct packed {
    logic                      clear;
    logic                      sample;
    logic [NPPS_BIT_IDX_W-1:0] bit_idx;
  } npps_lane_ctrl_t;

  // Line levels and status after the current tick.
  typedef struct packed {
    logic latch_level;
    logic clock_level;
    logic busy;
    logic done;
  } npps_tick_res_t;

endpackage

### rtl/core/npps_if.sv
// ----------------------------------------------------------------------------
// NES pad poll sequencer channels
// Valid/ready channel interfaces for the tick input and the result output.
// ----------------------------------------------------------------------------
interface npps_in_if
  import npps_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      start_req;
  logic [NPPS_PIN_SLOTS-1:0] data_pins;

  modport source (output valid, output start_req, output data_pins, input ready);
  modport sink   (input valid, input start_req, input data_pins, output ready);
endinterface

interface npps_out_if
  import npps_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      latch_level;
  logic                      clock_level;
  logic                      busy_res;
  logic                      done_res;
  logic [NPPS_BUTTONS_W-1:0] buttons;

  modport source (output valid, output latch_level, output clock_level, output busy_res,
                  output done_res, output buttons, input ready);
  modport sink   (input valid, input latch_level, input clock_level, input busy_res,
                  input done_res, input buttons, output ready);
endinterface

### rtl/core/npps_lane.sv
// ----------------------------------------------------------------------------
// NES pad poll sampling lane
// Collects the serial bits of one pad slot and presents them as pressed buttons.
// ----------------------------------------------------------------------------
module npps_lane
  import npps_pkg::*;
(
  input  logic                         clk,
  input  npps_lane_ctrl_t              ctrl,
  input  logic                         pin,
  output logic [NPPS_BITS_PER_PAD-1:0] pressed
);

  logic [NPPS_BITS_PER_PAD-1:0] store_r;
  logic [NPPS_BITS_PER_PAD-1:0] store_nxt;

  // The first bit shifted out (button A) lands in the top bit.
  always_comb begin
    store_nxt = store_r;
    if (ctrl.clear) begin
      store_nxt = '0;
    end else if (ctrl.sample && pin) begin
      store_nxt[NPPS_LAST_BIT - ctrl.bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

  // The data line is active low.
  assign pressed = ~store_r;

endmodule

### rtl/core/npps_seq.sv
// ----------------------------------------------------------------------------
// NES pad poll stage sequencer
// Steps through the latch and clock stages once per accepted tick.
// ----------------------------------------------------------------------------
module npps_seq
  import npps_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tick,
  input  logic            start_req,
  output npps_lane_ctrl_t lane_ctrl,
  output npps_tick_res_t  tick_res
);

  npps_stage_t               stage_r, stage_nxt;
  logic [NPPS_BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic                      running_r, running_nxt;
  logic                      latch_r, latch_nxt;
  logic                      clock_r, clock_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= ST_LATCH_ON;
      bit_idx_r <= '0;
      running_r <= 1'b0;
      latch_r   <= 1'b0;
      clock_r   <= 1'b0;
    end else begin
      stage_r   <= stage_nxt;
      bit_idx_r <= bit_idx_nxt;
      running_r <= running_nxt;
      latch_r   <= latch_nxt;
      clock_r   <= clock_nxt;
    end
  end

  always_comb begin
    npps_stage_t               stage_cur;
    logic [NPPS_BIT_IDX_W-1:0] bit_cur;
    logic                      starting;
    logic                      done;

    // A start while idle begins a poll, and its first stage runs on the same tick.
    starting    = tick && !running_r && start_req;
    stage_cur   = running_r ? stage_r : ST_LATCH_ON;
    bit_cur     = running_r ? bit_idx_r : '0;
    done        = 1'b0;
    stage_nxt   = stage_r;
    bit_idx_nxt = bit_idx_r;
    running_nxt = running_r;
    latch_nxt   = latch_r;
    clock_nxt   = clock_r;
    lane_ctrl   = '{clear: starting, sample: 1'b0, bit_idx: bit_cur};

    if (tick && (running_r || start_req)) begin
      running_nxt = 1'b1;
      bit_idx_nxt = bit_cur;
      unique case (stage_cur)
        ST_LATCH_ON: begin
          latch_nxt = 1'b1;
          clock_nxt = 1'b0;
          stage_nxt = ST_SAMPLE_A;
        end
        ST_SAMPLE_A: begin
          lane_ctrl.sample = 1'b1;
          stage_nxt        = ST_WAIT_A;
        end
        ST_WAIT_A: begin
          stage_nxt = ST_LATCH_OFF;
        end
        ST_LATCH_OFF: begin
          latch_nxt = 1'b0;
          stage_nxt = ST_WAIT_B;
        end
        ST_WAIT_B: begin
          stage_nxt = ST_CLOCK_UP;
        end
        ST_CLOCK_UP: begin
          if (bit_cur == NPPS_LAST_BIT) begin
            done        = 1'b1;
            running_nxt = 1'b0;
            stage_nxt   = ST_LATCH_ON;
            bit_idx_nxt = '0;
          end else begin
            clock_nxt   = 1'b1;
            bit_idx_nxt = bit_cur + 1'b1;
            stage_nxt   = ST_CLOCK_DOWN;
          end
        end
        ST_CLOCK_DOWN: begin
          lane_ctrl.sample = 1'b1;
          clock_nxt        = 1'b0;
          stage_nxt        = ST_CLOCK_UP;
        end
        default: begin
          stage_nxt = ST_CLOCK_UP;
        end
      endcase
    end

    tick_res = '{latch_level: latch_nxt, clock_level: clock_nxt,
                 busy: running_nxt, done: done};
  end

endmodule

### rtl/core/nes_pad_poll_sequencer_core.sv
// ----------------------------------------------------------------------------
// NES pad poll sequencer core
// Drives the shared latch and clock lines of several NES pads and reads them.
// ----------------------------------------------------------------------------
// Every input transfer is one timer tick carrying a start request and the data
// line level of each pad slot; every tick yields exactly one result transfer
// with the latch and clock levels to drive, the busy flag and, on the tick a
// poll finishes, the pressed buttons of every pad (A in bit 7 of each byte).
// The block takes one tick per clock cycle: the stage sequencer and the
// sampling lanes update in the cycle the tick is accepted, and the result sits
// in an output register, so a new tick is taken while that register is empty
// or being drained in the same cycle. A full poll spans 20 ticks from the
// start request to the finishing tick: five for the latch stages, then a pair
// of clock stages for each of the seven later bits, then the finishing tick.
module nes_pad_poll_sequencer_core
  import npps_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  npps_in_if.sink           in_ch,
  npps_out_if.source        out_ch
);

  // Pads beyond the available data pins are never read.
  localparam int LANES = (SLOTS < NPPS_PIN_SLOTS) ? SLOTS : NPPS_PIN_SLOTS;

  logic                         tick;
  npps_lane_ctrl_t              lane_ctrl;
  npps_tick_res_t               tick_res;
  logic [NPPS_BITS_PER_PAD-1:0] pressed [LANES];
  logic [NPPS_BUTTONS_W-1:0]    buttons_merged;

  logic                         out_valid_r, out_valid_nxt;
  npps_tick_res_t               res_r;
  logic [NPPS_BUTTONS_W-1:0]    buttons_r;

  // A tick is taken whenever the result register can accept its result.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign tick        = in_ch.valid && in_ch.ready;

  npps_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .start_req (in_ch.start_req),
    .lane_ctrl (lane_ctrl),
    .tick_res  (tick_res)
  );

  // One sampling lane per pad slot; they all follow the same sequencer control.
  for (genvar n = 0; n < LANES; n++) begin : g_lane
    npps_lane u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .pin     (in_ch.data_pins[n]),
      .pressed (pressed[n])
    );
  end

  // Merge the lane bytes into the buttons word. No sample is taken on the
  // finishing tick, so the lane stores already hold the final bits.
  always_comb begin
    buttons_merged = '0;
    for (int n = 0; n < LANES; n++) begin
      buttons_merged[n*NPPS_BITS_PER_PAD +: NPPS_BITS_PER_PAD] = pressed[n];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: the buttons word reads zero except on the finishing tick.
  always_ff @(posedge clk) begin
    if (tick) begin
      res_r     <= tick_res;
      buttons_r <= tick_res.done ? buttons_merged : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.latch_level = res_r.latch_level;
  assign out_ch.clock_level = res_r.clock_level;
  assign out_ch.busy_res    = res_r.busy;
  assign out_ch.done_res    = res_r.done;
  assign out_ch.buttons     = buttons_r;

`ifndef SYNTHESIS
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done) |-> !res_r.busy)
    else $error("poll reported done while still busy");

  a_buttons_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.done) |-> (buttons_r == '0))
    else $error("buttons reported outside the finishing tick");

  a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.latch_level && res_r.clock_level))
    else $error("latch and clock lines both high");
`endif

endmodule

### tb/sv/nes_pad_poll_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// NES pad poll sequencer core testbench
// Sends timer ticks with random pad pin levels and start requests, predicts
// every result transfer in a small tracker class and compares them in order.
// ----------------------------------------------------------------------------
module nes_pad_poll_sequencer_core_tb;
  import npps_pkg::*;

  localparam int SLOTS       = 4;
  // Roughly how many ticks the whole run sends, the directed part included.
  localparam int TICK_COUNT  = 700;
  // Percentage of cycles in which either side holds off.
  localparam int IDLE_PCT    = 7;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  // Ticks sent for one poll: the 20 from the start request to the finishing
  // tick, plus the tick just after it.
  localparam int POLL_TICKS  = 21;

  // One result transfer as the block should present it.
  typedef struct packed {
    logic                      latch_level;
    logic                      clock_level;
    logic                      busy;
    logic                      done;
    logic [NPPS_BUTTONS_W-1:0] buttons;
  } poll_result_t;

  // Tracks the sequencer's state from the accepted ticks and keeps the results
  // that are still owed by the block, oldest first.
  class poll_tracker;
    npps_stage_t               stage;
    logic [NPPS_BIT_IDX_W-1:0] bit_idx;
    logic                      running;
    logic                      latch_q;
    logic                      clock_q;
    logic [NPPS_BUTTONS_W-1:0] raw_samples;
    poll_result_t              owed_results[$];
    int unsigned               compared;
    int unsigned               mismatches;
    int unsigned               polls_done;

    function new();
      stage       = ST_LATCH_ON;
      bit_idx     = '0;
      running     = 1'b0;
      latch_q     = 1'b0;
      clock_q     = 1'b0;
      raw_samples = '0;
      compared    = 0;
      mismatches  = 0;
      polls_done  = 0;
    endfunction

    // Raw pin level of slot n, sample i, goes to bit 8n+(7-i).
    function void take_sample(logic [NPPS_PIN_SLOTS-1:0] pins);
      for (int n = 0; n < SLOTS && n < NPPS_PIN_SLOTS; n++) begin
        if (pins[n]) raw_samples[8*n + 7 - int'(bit_idx)] = 1'b1;
      end
    endfunction

    function void note_tick(logic start, logic [NPPS_PIN_SLOTS-1:0] pins);
      poll_result_t              res;
      logic [NPPS_BUTTONS_W-1:0] keep;
      logic                      done;
      done = 1'b0;
      if (!running && start) begin
        running     = 1'b1;
        stage       = ST_LATCH_ON;
        bit_idx     = '0;
        raw_samples = '0;
      end
      if (running) begin
        case (stage)
          ST_LATCH_ON: begin
            latch_q = 1'b1;
            clock_q = 1'b0;
            stage   = ST_SAMPLE_A;
          end
          ST_SAMPLE_A: begin
            take_sample(pins);
            stage = ST_WAIT_A;
          end
          ST_WAIT_A:    stage = ST_LATCH_OFF;
          ST_LATCH_OFF: begin
            latch_q = 1'b0;
            stage   = ST_WAIT_B;
          end
          ST_WAIT_B:    stage = ST_CLOCK_UP;
          ST_CLOCK_UP: begin
            if (bit_idx >= NPPS_LAST_BIT) begin
              done    = 1'b1;
              running = 1'b0;
              stage   = ST_LATCH_ON;
              bit_idx = '0;
            end else begin
              clock_q = 1'b1;
              bit_idx = bit_idx + 1'b1;
              stage   = ST_CLOCK_DOWN;
            end
          end
          ST_CLOCK_DOWN: begin
            take_sample(pins);
            clock_q = 1'b0;
            stage   = ST_CLOCK_UP;
          end
          default: stage = ST_CLOCK_UP;
        endcase
      end
      keep = '0;
      for (int n = 0; n < SLOTS && n < NPPS_PIN_SLOTS; n++) keep[8*n +: 8] = 8'hFF;
      res.latch_level = latch_q;
      res.clock_level = clock_q;
      res.busy        = running;
      res.done        = done;
      res.buttons     = done ? (~raw_samples & keep) : '0;
      if (done) polls_done++;
      owed_results.push_back(res);
    endfunction

    function void check_result(poll_result_t got);
      poll_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Result with nothing owed: latch=%b clock=%b busy=%b done=%b buttons=%h",
                   got.latch_level, got.clock_level, got.busy, got.done, got.buttons);
        return;
      end
      want = owed_results.pop_front();
      compared++;
      if (got.latch_level !== want.latch_level || got.clock_level !== want.clock_level ||
          got.busy !== want.busy || got.done !== want.done ||
          got.buttons !== want.buttons) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("Result %0d wrong: want latch=%b clock=%b busy=%b done=%b buttons=%h",
                   compared, want.latch_level, want.clock_level, want.busy, want.done,
                   want.buttons);
          $display("                  got  latch=%b clock=%b busy=%b done=%b buttons=%h",
                   got.latch_level, got.clock_level, got.busy, got.done, got.buttons);
        end
      end
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    // Anything still owed once the block has gone quiet is a missing result.
    function void close();
      if (owed_results.size() != 0) begin
        $display("%0d results never arrived", owed_results.size());
        mismatches += owed_results.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  npps_in_if  in_ch ();
  npps_out_if out_ch ();

  nes_pad_poll_sequencer_core #(
    .SLOTS (SLOTS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  poll_tracker tracker;
  // Set while both sides are to run flat out with no hold-offs at all.
  logic        steady;
  int unsigned ticks_sent;
  int unsigned quiet_cycles;

  always #5 clk = ~clk;

  // The result side: ready drops now and then, except in the steady stretch.
  // It changes on the falling edge so the rising edge always sees a settled value.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor. Both channels are sampled on the rising edge, before the block's
  // own registers update. Every input transfer is handed to the tracker, which
  // owes exactly one result for it; every result transfer is checked against
  // the oldest of those. Any transfer on either side resets the hang watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) tracker.note_tick(in_ch.start_req, in_ch.data_pins);
      if (out_ch.valid && out_ch.ready)
        tracker.check_result('{out_ch.latch_level, out_ch.clock_level, out_ch.busy_res,
                               out_ch.done_res, out_ch.buttons});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("No transfer for %0d cycles, giving up", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Pin levels for one tick. Mostly random, with a fair share of all pads
  // released or all pads pressed on every line.
  function automatic logic [NPPS_PIN_SLOTS-1:0] pick_pins();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return '0;
    if (roll < 16) return '1;
    return NPPS_PIN_SLOTS'($urandom);
  endfunction

  // Offers one tick on the input channel and returns on the falling edge after
  // its transfer. It is entered on a falling edge, so valid is only ever set
  // once per time step, either to idle or to offer the tick.
  task automatic send_tick(input logic start, input logic [NPPS_PIN_SLOTS-1:0] pins);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= start;
    in_ch.data_pins <= pins;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  // One poll with random content: a start request, then the remaining ticks
  // with random pins and stray start requests, which a busy block must ignore.
  // Stray starts also land on the finishing tick and just after it.
  task automatic run_poll();
    send_tick(1'b1, pick_pins());
    for (int t = 1; t < POLL_TICKS; t++) send_tick($urandom_range(0, 3) == 0, pick_pins());
  endtask

  initial begin
    tracker         = new();
    steady          = 1'b0;
    ticks_sent      = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.start_req = 1'b0;
    in_ch.data_pins = '0;
    out_ch.ready    = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. An idle tick first, which must leave everything low. Then
    // one poll with the start request held high all the way through, so it is
    // seen while busy and on the finishing tick itself. The pins cycle through
    // all pressed, all released and the two alternating patterns, so the sample
    // points see both extremes and one alternating pattern. The tick after the
    // finishing one starts a fresh poll, which must clear the samples of the one
    // before, and one more tick takes its first sample.
    send_tick(1'b0, 4'hF);
    for (int t = 0; t < POLL_TICKS; t++) begin
      case (t % 4)
        0:       send_tick(1'b1, 4'h0);
        1:       send_tick(1'b1, 4'hF);
        2:       send_tick(1'b1, 4'h5);
        default: send_tick(1'b1, 4'hA);
      endcase
    end
    send_tick(1'b1, 4'hF);

    // Random part. Mostly whole polls, with short runs of ticks that carry no
    // start request in between. A stretch in the middle runs with no idling on
    // either side at all.
    while (ticks_sent < TICK_COUNT) begin
      steady = (ticks_sent >= 300) && (ticks_sent < 450);
      if ($urandom_range(0, 99) < 85) begin
        run_poll();
      end else begin
        repeat ($urandom_range(1, 3)) send_tick(1'b0, pick_pins());
      end
    end
    steady      = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed result, then let the output register run on
    // to show anything stray.
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    tracker.close();

    $display("Sent %0d ticks, %0d polls finished, %0d results compared, %0d mismatches.",
             ticks_sent, tracker.polls_done, tracker.compared, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
